[sv/refcounted_slot_allocator_top_assert.svh]
// Assertion macros shared by the slot allocator modules.
`ifndef REFCOUNTED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RSA_ASSERT_IMP(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define RSA_ASSERT_NEXT(name, clk_i, rstn_i, ante, cons, msg) \
	name: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rsa_pkg.sv]
// Types, codes and constants shared by the slot allocator modules.
package rsa_pkg;

	// Default pool size.
	localparam int SLOTS_DEFAULT = 16;

	// Fixed field widths of the items.
	localparam int OP_W      = 2;
	localparam int SLOT_IN_W = 4;
	localparam int COUNT_W   = 8;
	localparam int STATUS_W  = 2;
	localparam int GRANT_W   = 4;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd0;
	localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd1;
	localparam logic [OP_W-1:0] OP_UNACQ   = 2'd2;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd3;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_IN_USE  = 2'd2;

	// Request item.
	typedef struct packed {
		logic [OP_W-1:0]      opcode;
		logic [SLOT_IN_W-1:0] slot;
		logic [COUNT_W-1:0]   release_count;
	} req_t;

	// Response item.
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [GRANT_W-1:0]  granted_slot;
	} rsp_t;

	// Control of the free ring.
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} ring_ctl_t;

endpackage

[sv/rsa_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/rsa_ring.sv]
// Free-slot ring: RAM, per-entry valid bits for the refill value, write forwarding.
module rsa_ring #(
	parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rsa_pkg::ring_ctl_t       ctl,
	input  logic [$clog2(SLOTS)-1:0] rd_addr,
	input  logic [$clog2(SLOTS)-1:0] wr_addr,
	input  logic [$clog2(SLOTS)-1:0] wr_data,
	output logic [$clog2(SLOTS)-1:0] rd_data
);

	localparam int SLOT_W = $clog2(SLOTS);

	logic [SLOTS-1:0]  valid_q;
	logic [SLOT_W-1:0] addr_s1;
	logic              byp_s1;
	logic [SLOT_W-1:0] byp_data_s1;
	logic [SLOT_W-1:0] ram_q;

	rsa_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ctl.wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (ctl.rd_en),
		.raddr(rd_addr),
		.rdata(ram_q)
	);

	// An entry that was not written since the last refill holds its own index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (ctl.clear) begin
			valid_q <= '0;
		end else if (ctl.wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// Remember the read address and catch a write to it in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_s1 <= 1'b0;
		end else if (ctl.rd_en) begin
			byp_s1 <= ctl.wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			addr_s1     <= rd_addr;
			byp_data_s1 <= wr_data;
		end
	end

	// Resolve the entry: forwarded write, stored value or refill value.
	assign rd_data = byp_s1 ? byp_data_s1 : (valid_q[addr_s1] ? ram_q : addr_s1);

endmodule

[sv/refcounted_slot_allocator_top.sv]
// Reference-counted slot allocator: pipeline control, use counts and result register.
//
// Usage:
//   The req channel (req_valid, req_stall, req) carries one operation per item:
//   clear, acquire, unacquire or release. The rsp channel (rsp_valid, rsp_stall,
//   rsp) returns exactly one item per request, in order, with a status and the
//   granted slot number. An item moves on a channel at a clock edge where valid
//   is high and stall is low.
//   The free ring and the use-count RAM are read at the edge that accepts a
//   request; the update stage then waits for a free response register, updates
//   state and loads the response register, from which the response is taken.
//   Throughput is one item per cycle while the response is not stalled. Back-to-back
//   hazards on the same ring or count entry are resolved by forwarding the write
//   of the item ahead. When rsp_stall holds a full response register, the item in
//   the update stage waits and req_stall rises until the response is taken.
//   After arst_n the ring holds every slot in order, the take pointer is zero
//   and the give-back pointer is SLOTS minus one. The use counts hold no reset
//   value; a release of a slot never acquired since reset is not allowed.
//   The ring is refilled at reset and on clear through per-entry valid bits,
//   so no clearing pass is needed and the block is ready right after reset.
`include "refcounted_slot_allocator_top_assert.svh"

module refcounted_slot_allocator_top #(
	parameter int SLOTS = rsa_pkg::SLOTS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rsa_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rsa_pkg::rsp_t rsp
);

	localparam int                SLOT_W  = $clog2(SLOTS);
	localparam int                COUNT_W = rsa_pkg::COUNT_W;
	localparam int                GRANT_W = rsa_pkg::GRANT_W;
	localparam logic [SLOT_W-1:0] LAST    = SLOT_W'(SLOTS - 1);

	logic                         req_acc;
	logic                         out_free;
	logic                         fire_s1;
	logic [8:0]                   slot_red;
	logic [SLOT_W-1:0]            slot_mod;

	logic                         valid_s1;
	logic [rsa_pkg::OP_W-1:0]     op_s1;
	logic [SLOT_W-1:0]            slot_s1;
	logic [COUNT_W-1:0]           drop_s1;
	logic                         cnt_byp_s1;
	logic [COUNT_W-1:0]           cnt_byp_data_s1;

	logic [SLOT_W-1:0]            take_q;
	logic [SLOT_W-1:0]            give_q;
	logic [SLOT_W-1:0]            take_d;
	logic [SLOT_W-1:0]            give_d;
	logic [SLOT_W-1:0]            take_inc;
	logic [SLOT_W-1:0]            take_dec;
	logic [SLOT_W-1:0]            give_inc;

	rsa_pkg::ring_ctl_t           ring_ctl;
	logic [SLOT_W-1:0]            ring_slot;
	logic [SLOT_W-1:0]            ring_waddr;
	logic [SLOT_W-1:0]            ring_wdata;

	logic                         cnt_we;
	logic [SLOT_W-1:0]            cnt_waddr;
	logic [COUNT_W-1:0]           cnt_wdata;
	logic [COUNT_W-1:0]           cnt_q;
	logic [COUNT_W-1:0]           cnt_cur;
	logic [COUNT_W-1:0]           cnt_left;

	rsa_pkg::rsp_t                rsp_d;
	rsa_pkg::rsp_t                rsp_q;
	logic                         rsp_valid_q;

	// Handshake: the update stage waits only on a full, stalled response register.
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign fire_s1   = valid_s1 && out_free;
	assign req_stall = valid_s1 && !out_free;
	assign req_acc   = req_valid && !req_stall;

	// Reduce the requested slot number into the pool range by repeated subtraction.
	always_comb begin
		slot_red = 9'(req.slot);
		for (int i = 0; i < 8; i++) begin
			if (slot_red >= 9'(SLOTS)) begin
				slot_red = slot_red - 9'(SLOTS);
			end
		end
	end
	assign slot_mod = SLOT_W'(slot_red);

	// Pointer steps, wrapping within the pool.
	assign take_inc = (take_q == LAST) ? '0 : take_q + SLOT_W'(1);
	assign take_dec = (take_q == '0) ? LAST : take_q - SLOT_W'(1);
	assign give_inc = (give_q == LAST) ? '0 : give_q + SLOT_W'(1);

	// Use count seen by a release, with the write of the item ahead forwarded.
	assign cnt_cur  = cnt_byp_s1 ? cnt_byp_data_s1 : cnt_q;
	assign cnt_left = cnt_cur - drop_s1;

	// Update stage: apply the operation, drive memory writes and build the result.
	always_comb begin
		take_d         = take_q;
		give_d         = give_q;
		// The ring is read at the take pointer the next item will see.
		ring_ctl.rd_en = req_acc;
		ring_ctl.wr_en = 1'b0;
		ring_ctl.clear = 1'b0;
		ring_waddr     = give_inc;
		ring_wdata     = slot_s1;
		cnt_we         = 1'b0;
		cnt_waddr      = slot_s1;
		cnt_wdata      = cnt_left;
		rsp_d.status       = rsa_pkg::ST_OK;
		rsp_d.granted_slot = '0;
		if (fire_s1) begin
			case (op_s1)
				rsa_pkg::OP_CLEAR: begin
					take_d         = '0;
					give_d         = LAST;
					ring_ctl.clear = 1'b1;
				end
				rsa_pkg::OP_ACQUIRE: begin
					if (take_q == give_q) begin
						rsp_d.status = rsa_pkg::ST_NO_FREE;
					end else begin
						take_d             = take_inc;
						cnt_we             = 1'b1;
						cnt_waddr          = ring_slot;
						cnt_wdata          = COUNT_W'(1);
						rsp_d.granted_slot = GRANT_W'(ring_slot);
					end
				end
				rsa_pkg::OP_UNACQ: begin
					take_d = take_dec;
				end
				rsa_pkg::OP_RELEASE: begin
					cnt_we = 1'b1;
					if (cnt_left != '0) begin
						rsp_d.status = rsa_pkg::ST_IN_USE;
					end else begin
						give_d         = give_inc;
						ring_ctl.wr_en = 1'b1;
					end
				end
				default: begin
					rsp_d.status = rsa_pkg::ST_OK;
				end
			endcase
		end
	end

	rsa_ring #(
		.SLOTS(SLOTS)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.rd_addr(take_d),
		.wr_addr(ring_waddr),
		.wr_data(ring_wdata),
		.rd_data(ring_slot)
	);

	rsa_ram #(
		.WIDTH(COUNT_W),
		.DEPTH(SLOTS)
	) u_counts (
		.clk  (clk),
		.we   (cnt_we),
		.waddr(cnt_waddr),
		.wdata(cnt_wdata),
		.re   (req_acc),
		.raddr(slot_mod),
		.rdata(cnt_q)
	);

	// Pointers and stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			take_q     <= '0;
			give_q     <= LAST;
			valid_s1   <= 1'b0;
			cnt_byp_s1 <= 1'b0;
		end else begin
			take_q <= take_d;
			give_q <= give_d;
			if (req_acc) begin
				valid_s1   <= 1'b1;
				cnt_byp_s1 <= cnt_we && (cnt_waddr == slot_mod);
			end else if (fire_s1) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// Request payload for the update stage.
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_s1           <= req.opcode;
			slot_s1         <= slot_mod;
			drop_s1         <= req.release_count;
			cnt_byp_data_s1 <= cnt_wdata;
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Both pointers stay within the pool.
	`RSA_ASSERT_IMP(a_ptr_range, clk, arst_n, 1'b1, (take_q <= LAST) && (give_q <= LAST), "pointer out of pool range")

	// A clear restores both pointers.
	`RSA_ASSERT_NEXT(a_clear_ptrs, clk, arst_n, fire_s1 && (op_s1 == rsa_pkg::OP_CLEAR), (take_q == '0) && (give_q == LAST), "clear did not restore pointers")

	// An acquire with equal pointers reports no free slot.
	`RSA_ASSERT_NEXT(a_no_free, clk, arst_n, fire_s1 && (op_s1 == rsa_pkg::OP_ACQUIRE) && (take_q == give_q), rsp_valid_q && (rsp_q.status == rsa_pkg::ST_NO_FREE), "empty ring not reported")

	// Only a successful acquire carries a slot number.
	`RSA_ASSERT_IMP(a_grant_zero, clk, arst_n, rsp_valid_q && (rsp_q.status != rsa_pkg::ST_OK), rsp_q.granted_slot == '0, "failed item carries a slot")

	// An accepted item always reaches the update stage.
	`RSA_ASSERT_NEXT(a_accept_s1, clk, arst_n, req_acc, valid_s1, "accepted item lost")

endmodule
